>>> rtl/core/bas_pkg.sv
// Shared constants, types and helper functions of the barcode alignment sequencer.
package bas_pkg;

  // Field and datapath widths.
  localparam int HEIGHT_BITS    = 12;
  localparam int RATIO_BITS     = 10;
  localparam int FRAC_BITS      = 14;
  localparam int ANGLE_BITS     = FRAC_BITS + 1;
  localparam int PITCH_BITS     = 16;
  localparam int COUNT_BITS     = 8;
  localparam int MODE_BITS      = 3;
  localparam int RATE_BITS      = 15;
  localparam int IFT_BITS       = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam int XY_BITS        = FRAC_BITS + 4;
  localparam int Z_BITS         = FRAC_BITS + 3;
  localparam int CORDIC_STEPS   = 14;
  localparam int STEP_BITS      = 4;

  // Angle and pitch constants.
  localparam logic [ANGLE_BITS-1:0]        TILT_MAX   = ANGLE_BITS'(25736);
  localparam logic signed [PITCH_BITS-1:0] PITCH_DOWN = -PITCH_BITS'(23040);
  localparam logic [COUNT_BITS-1:0]        COUNT_MAX  = {COUNT_BITS{1'b1}};

  // Operating modes.
  localparam logic [MODE_BITS-1:0] MODE_OFF   = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_FIND  = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_LEARN = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_BACK  = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_RECT  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_REQUIRED_COUNT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ANGLE_TOL      = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MOVE_RATE      = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INV_FRAME_TIME = 2'd3;

  // Register values after reset.
  localparam logic [COUNT_BITS-1:0] RESET_REQUIRED_COUNT = 8'd3;
  localparam logic [ANGLE_BITS-1:0] RESET_ANGLE_TOL      = 15'd1144;
  localparam logic [RATE_BITS-1:0]  RESET_MOVE_RATE      = 15'd256;
  localparam logic [IFT_BITS-1:0]   RESET_INV_FRAME_TIME = 16'd7680;

  // Request from the sequencer to the tilt unit.
  typedef struct packed {
    logic                   start;
    logic [HEIGHT_BITS-1:0] height;
    logic [HEIGHT_BITS-1:0] peak;
  } tilt_req_t;

  // Answer of the tilt unit.
  typedef struct packed {
    logic                  done;
    logic [ANGLE_BITS-1:0] tilt;
  } tilt_rsp_t;

  // Arctangent of 2^-i in radians Q2.14.
  function automatic logic [Z_BITS-1:0] atan_entry(input logic [STEP_BITS-1:0] i);
    logic [Z_BITS-1:0] a;
    case (i)
      4'd0:    a = Z_BITS'(12868);
      4'd1:    a = Z_BITS'(7596);
      4'd2:    a = Z_BITS'(4014);
      4'd3:    a = Z_BITS'(2037);
      4'd4:    a = Z_BITS'(1023);
      4'd5:    a = Z_BITS'(512);
      4'd6:    a = Z_BITS'(256);
      4'd7:    a = Z_BITS'(128);
      4'd8:    a = Z_BITS'(64);
      4'd9:    a = Z_BITS'(32);
      4'd10:   a = Z_BITS'(16);
      4'd11:   a = Z_BITS'(8);
      4'd12:   a = Z_BITS'(4);
      4'd13:   a = Z_BITS'(2);
      default: a = '0;
    endcase
    return a;
  endfunction

  // Arithmetic right shift that rounds toward zero.
  function automatic logic signed [XY_BITS-1:0] shr_tz(input logic signed [XY_BITS-1:0] v,
                                                        input logic [STEP_BITS-1:0] s);
    logic [XY_BITS-1:0] mag;
    mag = v[XY_BITS-1] ? XY_BITS'(-v) : XY_BITS'(v);
    mag = mag >> s;
    return v[XY_BITS-1] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

>>> rtl/core/bas_tilt.sv
// Iterative tilt unit: ratio division, square root and vectoring CORDIC on one step datapath.
module bas_tilt (
  input  logic               clk,
  input  logic               rst,
  input  bas_pkg::tilt_req_t req,
  output bas_pkg::tilt_rsp_t rsp
);
  import bas_pkg::*;

  localparam int XS_BITS   = FRAC_BITS + 1;
  localparam int SQ_BITS   = 2 * XS_BITS;
  localparam int ROOT_BITS = 2 * FRAC_BITS + 1;
  localparam int REM_BITS  = HEIGHT_BITS + 1;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_DIV    = 3'd1;
  localparam logic [2:0] PH_SQR    = 3'd2;
  localparam logic [2:0] PH_ROOT   = 3'd3;
  localparam logic [2:0] PH_CORDIC = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  localparam logic [SQ_BITS-1:0]   ONE_SQ    = SQ_BITS'(1) << (2 * FRAC_BITS);
  localparam logic [ROOT_BITS-1:0] ROOT_TOP  = ROOT_BITS'(1) << (2 * FRAC_BITS);
  localparam logic [RATIO_BITS:0]  RATIO_ONE = (RATIO_BITS + 1)'(1) << RATIO_BITS;

  logic [2:0]                 phase;
  logic [STEP_BITS-1:0]       step;
  logic [HEIGHT_BITS-1:0]     peak;
  logic [REM_BITS-1:0]        rem;
  logic [RATIO_BITS:0]        quo;
  logic [ROOT_BITS-1:0]       v;
  logic [SQ_BITS-1:0]         r;
  logic [ROOT_BITS-1:0]       bitv;
  logic signed [XY_BITS-1:0]  x;
  logic signed [XY_BITS-1:0]  y;
  logic signed [Z_BITS-1:0]   z;

  logic [REM_BITS-1:0]        rem2;
  logic                       div_take;
  logic [XS_BITS-1:0]         xs;
  logic [SQ_BITS-1:0]         xs_sq;
  logic [SQ_BITS-1:0]         root_sum;
  logic                       root_take;
  logic [SQ_BITS-1:0]         r_next;
  logic signed [XY_BITS-1:0]  dx;
  logic signed [XY_BITS-1:0]  dy;
  logic signed [Z_BITS-1:0]   da;

  // One restoring division step.
  assign rem2     = {rem[REM_BITS-2:0], 1'b0};
  assign div_take = rem2 >= REM_BITS'(peak);

  // Ratio scaled to Q.14 and its square.
  assign xs    = XS_BITS'(quo) << (FRAC_BITS - RATIO_BITS);
  assign xs_sq = xs * xs;

  // One square root step.
  assign root_sum  = r + SQ_BITS'(bitv);
  assign root_take = SQ_BITS'(v) >= root_sum;
  assign r_next    = root_take ? (r >> 1) + SQ_BITS'(bitv) : (r >> 1);

  // One CORDIC rotation step.
  assign dx = shr_tz(y, step);
  assign dy = shr_tz(x, step);
  assign da = $signed(atan_entry(step));

  // Step sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      step     <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (phase)
        PH_IDLE: begin
          if (req.start) begin
            peak <= req.peak;
            rem  <= REM_BITS'(req.height);
            step <= '0;
            if (req.peak == '0 || req.height >= req.peak) begin
              quo   <= RATIO_ONE;
              phase <= PH_SQR;
            end else begin
              quo   <= '0;
              phase <= PH_DIV;
            end
          end
        end
        PH_DIV: begin
          rem  <= div_take ? rem2 - REM_BITS'(peak) : rem2;
          quo  <= {quo[RATIO_BITS-1:0], div_take};
          step <= step + 1'b1;
          if (step == STEP_BITS'(RATIO_BITS - 1)) begin
            phase <= PH_SQR;
          end
        end
        PH_SQR: begin
          v     <= ROOT_BITS'(ONE_SQ - xs_sq);
          r     <= '0;
          bitv  <= ROOT_TOP;
          x     <= $signed(XY_BITS'(xs));
          phase <= PH_ROOT;
        end
        PH_ROOT: begin
          if (root_take) begin
            v <= ROOT_BITS'(SQ_BITS'(v) - root_sum);
          end
          r    <= r_next;
          bitv <= bitv >> 2;
          if (bitv[0]) begin
            y     <= $signed(XY_BITS'(r_next[FRAC_BITS:0]));
            z     <= '0;
            step  <= '0;
            phase <= PH_CORDIC;
          end
        end
        PH_CORDIC: begin
          if (y > 0) begin
            x <= x + dx;
            y <= y - dy;
            z <= z + da;
          end else if (y < 0) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - da;
          end
          step <= step + 1'b1;
          if (step == STEP_BITS'(CORDIC_STEPS - 1)) begin
            phase <= PH_DONE;
          end
        end
        PH_DONE: begin
          if (z < 0) begin
            rsp.tilt <= '0;
          end else if (z > $signed(Z_BITS'(TILT_MAX))) begin
            rsp.tilt <= TILT_MAX;
          end else begin
            rsp.tilt <= z[ANGLE_BITS-1:0];
          end
          rsp.done <= 1'b1;
          phase    <= PH_IDLE;
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/barcode_align_sequencer_unit.sv
// Top level of the barcode alignment sequencer: mode control, rate update and result port.
//
//  Channel   Signals                                             Direction
//  input     in_valid, in_ready, operation, detected, box_height request in
//  output    out_valid, out_ready, pitch_command, last_of_run,   request out
//            mode_after
//  config    cfg_write, cfg_index, cfg_data                      write only
//
// Toggle and off frames show no result. A searching frame shows its result in the
// cycle after acceptance, a detected rectifying frame after load, 10 division
// steps, squaring, 15 square root steps, 14 CORDIC steps and a clamp in the tilt
// unit, then tilt pickup, multiply and update; a saturated ratio skips the division
// steps, a finishing frame multiply and update. No new request while a result waits.
// Reset is synchronous and loads the register defaults and the off mode; a stalled
// output holds its result, and a two-result frame shows them in order.
module barcode_align_sequencer_unit (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic                                     operation,
  input  logic                                     detected,
  input  logic [bas_pkg::HEIGHT_BITS-1:0]          box_height,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [bas_pkg::PITCH_BITS-1:0]    pitch_command,
  output logic                                     last_of_run,
  output logic [bas_pkg::MODE_BITS-1:0]            mode_after,
  input  logic                                     cfg_write,
  input  logic [bas_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
  input  logic [bas_pkg::CFG_DATA_BITS-1:0]        cfg_data
);
  import bas_pkg::*;

  localparam int DIFF_BITS = ANGLE_BITS + 1;
  localparam int PROD_BITS = 2 * (IFT_BITS + 1);
  localparam int QMAG_BITS = PROD_BITS - FRAC_BITS;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_TILT   = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_UPD    = 3'd3;
  localparam logic [2:0] ST_SECOND = 3'd4;

  localparam logic [QMAG_BITS-1:0] POS_LIMIT = QMAG_BITS'(32767);
  localparam logic [QMAG_BITS-1:0] NEG_LIMIT = QMAG_BITS'(32768);

  // Configuration registers.
  logic [COUNT_BITS-1:0] required_count;
  logic [ANGLE_BITS-1:0] angle_tolerance;
  logic [RATE_BITS-1:0]  move_rate;
  logic [IFT_BITS-1:0]   inverse_frame_time;

  // Sequencer state.
  logic [2:0]                    state;
  logic [MODE_BITS-1:0]          mode;
  logic [COUNT_BITS-1:0]         frame_count;
  logic [HEIGHT_BITS-1:0]        peak_height;
  logic [ANGLE_BITS-1:0]         previous_tilt;
  logic signed [PITCH_BITS-1:0]  rate_estimate;
  logic signed [DIFF_BITS-1:0]   tilt_diff;
  logic signed [PROD_BITS-1:0]   product;

  tilt_req_t tilt_req;
  tilt_rsp_t tilt_rsp;

  logic                          accept;
  logic signed [PITCH_BITS-1:0]  pos_rate;
  logic signed [PITCH_BITS-1:0]  neg_rate;
  logic [COUNT_BITS-1:0]         count_inc;
  logic [COUNT_BITS-1:0]         tilt_count;
  logic [MODE_BITS-1:0]          frame_mode;
  logic [COUNT_BITS-1:0]         frame_count_new;
  logic [HEIGHT_BITS-1:0]        frame_peak;
  logic signed [PITCH_BITS-1:0]  frame_pitch;
  logic [PROD_BITS-1:0]          prod_mag;
  logic [QMAG_BITS-1:0]          qmag;
  logic                          q_neg;
  logic signed [PITCH_BITS-1:0]  rate_new;

  assign in_ready  = (state == ST_IDLE) && !out_valid;
  assign accept    = in_valid && in_ready;
  assign pos_rate  = $signed({1'b0, move_rate});
  assign neg_rate  = -$signed({1'b0, move_rate});
  assign count_inc = (frame_count == COUNT_MAX) ? frame_count : frame_count + 1'b1;

  // Tilt unit starts on a detected frame while rectifying.
  assign tilt_req.start  = accept && !operation && detected && (mode == MODE_RECT);
  assign tilt_req.height = box_height;
  assign tilt_req.peak   = peak_height;

  bas_tilt u_tilt (
    .clk (clk),
    .rst (rst),
    .req (tilt_req),
    .rsp (tilt_rsp)
  );

  // Frame count after a tilt inside the tolerance.
  assign tilt_count = (tilt_rsp.tilt < angle_tolerance) ? count_inc : frame_count;

  // Mode step for frames that need no tilt.
  always_comb begin
    frame_mode      = mode;
    frame_count_new = frame_count;
    frame_peak      = peak_height;
    frame_pitch     = rate_estimate;
    case (mode)
      MODE_FIND, MODE_BACK: begin
        frame_pitch = (mode == MODE_FIND) ? pos_rate : neg_rate;
        if (!detected) begin
          frame_count_new = '0;
        end else if (count_inc >= required_count) begin
          frame_count_new = '0;
          frame_mode      = (mode == MODE_FIND) ? MODE_LEARN : MODE_RECT;
        end else begin
          frame_count_new = count_inc;
        end
      end
      MODE_LEARN: begin
        frame_pitch = pos_rate;
        if (!detected) begin
          if (count_inc >= required_count) begin
            frame_count_new = '0;
            frame_mode      = MODE_BACK;
          end else begin
            frame_count_new = count_inc;
          end
        end else begin
          frame_count_new = '0;
          if (box_height > peak_height) begin
            frame_peak = box_height;
          end
        end
      end
      default: begin
        frame_pitch = rate_estimate;
      end
    endcase
  end

  // Rate update: truncate the product toward zero, follow the rate sign, saturate.
  assign prod_mag = product[PROD_BITS-1] ? PROD_BITS'(-product) : PROD_BITS'(product);
  assign qmag     = QMAG_BITS'(prod_mag >> FRAC_BITS);
  assign q_neg    = product[PROD_BITS-1] ^ rate_estimate[PITCH_BITS-1];
  always_comb begin
    if (rate_estimate == '0 || qmag == '0) begin
      rate_new = '0;
    end else if (q_neg) begin
      rate_new = (qmag >= NEG_LIMIT) ? $signed(PITCH_BITS'(NEG_LIMIT))
                                     : -$signed(PITCH_BITS'(qmag));
    end else begin
      rate_new = (qmag >= POS_LIMIT) ? $signed(PITCH_BITS'(POS_LIMIT))
                                     : $signed(PITCH_BITS'(qmag));
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      required_count     <= RESET_REQUIRED_COUNT;
      angle_tolerance    <= RESET_ANGLE_TOL;
      move_rate          <= RESET_MOVE_RATE;
      inverse_frame_time <= RESET_INV_FRAME_TIME;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_REQUIRED_COUNT: required_count     <= cfg_data[COUNT_BITS-1:0];
        REG_ANGLE_TOL:      angle_tolerance    <= cfg_data[ANGLE_BITS-1:0];
        REG_MOVE_RATE:      move_rate          <= cfg_data[RATE_BITS-1:0];
        REG_INV_FRAME_TIME: inverse_frame_time <= cfg_data[IFT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Main sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      mode          <= MODE_OFF;
      frame_count   <= '0;
      peak_height   <= '0;
      previous_tilt <= '0;
      rate_estimate <= -$signed({1'b0, RESET_MOVE_RATE});
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_SECOND) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (operation || mode == MODE_OFF) begin
              frame_count   <= '0;
              peak_height   <= '0;
              previous_tilt <= '0;
              rate_estimate <= neg_rate;
              if (operation) begin
                mode <= (mode == MODE_OFF) ? MODE_FIND : MODE_OFF;
              end
            end else if (mode == MODE_RECT && detected) begin
              state <= ST_TILT;
            end else begin
              mode          <= frame_mode;
              frame_count   <= frame_count_new;
              peak_height   <= frame_peak;
              out_valid     <= 1'b1;
              pitch_command <= frame_pitch;
              last_of_run   <= 1'b1;
              mode_after    <= frame_mode;
            end
          end
        end
        ST_TILT: begin
          if (tilt_rsp.done) begin
            previous_tilt <= tilt_rsp.tilt;
            frame_count   <= tilt_count;
            tilt_diff     <= $signed({1'b0, tilt_rsp.tilt}) - $signed({1'b0, previous_tilt});
            if (tilt_count >= required_count) begin
              mode          <= MODE_OFF;
              out_valid     <= 1'b1;
              pitch_command <= rate_estimate;
              last_of_run   <= 1'b0;
              mode_after    <= MODE_OFF;
              state         <= ST_SECOND;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          product <= PROD_BITS'((-(IFT_BITS + 1)'(tilt_diff)) * $signed({1'b0, inverse_frame_time}));
          state   <= ST_UPD;
        end
        ST_UPD: begin
          rate_estimate <= rate_new;
          out_valid     <= 1'b1;
          pitch_command <= rate_estimate;
          last_of_run   <= 1'b1;
          mode_after    <= MODE_RECT;
          state         <= ST_IDLE;
        end
        ST_SECOND: begin
          if (out_ready) begin
            pitch_command <= PITCH_DOWN;
            last_of_run   <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The tilt unit answers only while the sequencer waits for it.
  a_tilt_when_waiting: assert property (@(posedge clk) disable iff (rst)
    tilt_rsp.done |-> state == ST_TILT)
    else $error("tilt answer outside of the tilt wait");

  // A tilt never leaves its clamp range.
  a_tilt_range: assert property (@(posedge clk) disable iff (rst)
    tilt_rsp.done |-> tilt_rsp.tilt <= TILT_MAX)
    else $error("tilt above its maximum");

  // The first result of a finishing frame is followed by the pitch-down command.
  a_second_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_of_run) |=>
      (out_valid && last_of_run && pitch_command == PITCH_DOWN && mode_after == MODE_OFF))
    else $error("missing pitch-down result");

  // Only a finishing frame shows a result that is not the last one.
  a_first_is_finish: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_of_run) |-> (mode_after == MODE_OFF && mode == MODE_OFF))
    else $error("non-final result outside of a finishing frame");

endmodule

>>> verif/tb_barcode_align_sequencer_unit.sv
// Testbench of the barcode alignment sequencer: random and directed frames checked against a predictor.
module tb_barcode_align_sequencer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import bas_pkg::*;

  localparam int SETTLE_CYCLES = 64;
  localparam int PHASES        = 7;
  localparam int TILT_LIMIT    = 25736;
  localparam int DOWN_PITCH    = -23040;

  // One expected pitch result.
  typedef struct {
    logic signed [PITCH_BITS-1:0] pitch;
    logic                         last;
    logic [MODE_BITS-1:0]         mode;
  } pitch_result_t;

  // Predictor of the sequencer and store of the pitch results still due.
  class pitch_scoreboard;
    int unsigned          req_count;
    int unsigned          tol;
    int unsigned          move_rate;
    int unsigned          inv_frame_time;
    logic [MODE_BITS-1:0] mode;
    int unsigned          frame_count;
    int unsigned          peak_height;
    int unsigned          prev_tilt;
    int                   rate_estimate;
    pitch_result_t        pending_q[$];
    int                   errors;
    int                   atan_steps[14] = '{12868, 7596, 4014, 2037, 1023, 512, 256,
                                             128, 64, 32, 16, 8, 4, 2};

    function void reset_state();
      req_count      = 3;
      tol            = 1144;
      move_rate      = 256;
      inv_frame_time = 7680;
      mode           = MODE_OFF;
      errors         = 0;
      pending_q.delete();
      go_idle();
    endfunction

    function void go_idle();
      frame_count   = 0;
      peak_height   = 0;
      prev_tilt     = 0;
      rate_estimate = -int'(move_rate);
    endfunction

    function void count_up();
      if (frame_count < 255) frame_count++;
    endfunction

    function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_REQUIRED_COUNT: req_count = data[7:0];
        REG_ANGLE_TOL:      tol = data[14:0];
        REG_MOVE_RATE:      move_rate = data[14:0];
        REG_INV_FRAME_TIME: inv_frame_time = data;
        default: ;
      endcase
    endfunction

    // Tilt in radians Q2.14: acos of height over peak through a 14-step vectoring CORDIC.
    function int unsigned tilt_of_height(int unsigned h);
      longint unsigned ratio;
      int unsigned     xs;
      int unsigned     rem;
      int unsigned     root;
      int unsigned     bitv;
      int              x;
      int              y;
      int              z;
      int              dx;
      int              dy;
      ratio = (peak_height == 0) ? 1024 : ((longint'(h) << 10) / peak_height);
      if (ratio > 1024) ratio = 1024;
      xs = int'(ratio) << 4;
      rem = 32'h1000_0000 - xs * xs;
      root = 0;
      bitv = 32'h4000_0000;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
        if (rem >= root + bitv) begin
          rem  = rem - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv >>= 2;
      end
      x = int'(xs);
      y = int'(root);
      z = 0;
      for (int i = 0; i < 14; i++) begin
        dx = (y >= 0) ? (y >>> i) : -((-y) >>> i);
        dy = (x >= 0) ? (x >>> i) : -((-x) >>> i);
        if (y > 0) begin
          x = x + dx;
          y = y - dy;
          z = z + atan_steps[i];
        end else if (y < 0) begin
          x = x - dx;
          y = y + dy;
          z = z - atan_steps[i];
        end
      end
      if (z < 0) z = 0;
      if (z > TILT_LIMIT) z = TILT_LIMIT;
      return z;
    endfunction

    // Work out the pitch results of one accepted request and queue them.
    function void note_request(logic op, logic det, logic [HEIGHT_BITS-1:0] h);
      int            pitches[2];
      int            n;
      int unsigned   tilt;
      longint        d;
      longint        q;
      pitch_result_t e;
      n = 0;
      if (op) begin
        go_idle();
        mode = (mode == MODE_OFF) ? MODE_FIND : MODE_OFF;
        return;
      end
      if (mode == MODE_OFF) begin
        go_idle();
        return;
      end
      case (mode)
        MODE_FIND, MODE_BACK: begin
          pitches[n] = (mode == MODE_FIND) ? int'(move_rate) : -int'(move_rate);
          n = n + 1;
          if (!det) begin
            frame_count = 0;
          end else begin
            count_up();
            if (frame_count >= req_count) begin
              frame_count = 0;
              mode = (mode == MODE_FIND) ? MODE_LEARN : MODE_RECT;
            end
          end
        end
        MODE_LEARN: begin
          pitches[n] = int'(move_rate);
          n = n + 1;
          if (!det) begin
            count_up();
            if (frame_count >= req_count) begin
              frame_count = 0;
              mode = MODE_BACK;
            end
          end else begin
            frame_count = 0;
            if (h > peak_height) peak_height = h;
          end
        end
        default: begin
          pitches[n] = rate_estimate;
          n = n + 1;
          if (det) begin
            tilt = tilt_of_height(h);
            d = longint'(tilt) - longint'(prev_tilt);
            prev_tilt = tilt;
            if (tilt < tol) count_up();
            if (frame_count >= req_count) begin
              pitches[n] = DOWN_PITCH;
              n = n + 1;
              mode = MODE_OFF;
            end else begin
              // Rate follows the tilt change, with the sign of the present rate.
              q = (-d * longint'(inv_frame_time)) / 16384;
              if (rate_estimate < 0) q = -q;
              else if (rate_estimate == 0) q = 0;
              if (q > 32767) q = 32767;
              if (q < -32768) q = -32768;
              rate_estimate = int'(q);
            end
          end
        end
      endcase
      for (int k = 0; k < n; k++) begin
        e.pitch = PITCH_BITS'(pitches[k]);
        e.last  = (k == n - 1);
        e.mode  = mode;
        pending_q.push_back(e);
      end
    endfunction

    task report_mismatch(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
    endtask

    // Compare one pitch result with the oldest one due.
    task check_result(logic signed [PITCH_BITS-1:0] pitch, logic last,
                      logic [MODE_BITS-1:0] m);
      pitch_result_t e;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result, pitch %0d", pitch));
        return;
      end
      e = pending_q.pop_front();
      if (pitch !== e.pitch)
        report_mismatch($sformatf("pitch_command %0d, want %0d", pitch, e.pitch));
      if (last !== e.last)
        report_mismatch($sformatf("last_of_run %0b, want %0b", last, e.last));
      if (m !== e.mode)
        report_mismatch($sformatf("mode_after %0d, want %0d", m, e.mode));
    endtask
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          operation = 1'b0;
  logic                          detected = 1'b0;
  logic [HEIGHT_BITS-1:0]        box_height = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [PITCH_BITS-1:0]  pitch_command;
  logic                          last_of_run;
  logic [MODE_BITS-1:0]          mode_after;
  logic                          cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0]     cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]      cfg_data = '0;

  pitch_scoreboard sb;
  int              ready_style = 0;
  int              ready_left = 0;

  barcode_align_sequencer_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .detected     (detected),
    .box_height   (box_height),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pitch_command(pitch_command),
    .last_of_run  (last_of_run),
    .mode_after   (mode_after),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls: each stretch picks a readiness level, from always ready to long stalls.
  always @(negedge clk) begin
    if (rst) begin
      out_ready = 1'b0;
    end else begin
      if (ready_left == 0) begin
        ready_style = $urandom_range(0, 4);
        ready_left  = $urandom_range(20, 200);
      end
      ready_left--;
      case (ready_style)
        0:       out_ready = 1'b1;
        1:       out_ready = ($urandom_range(0, 3) != 0);
        2:       out_ready = ($urandom_range(0, 1) != 0);
        3:       out_ready = ($urandom_range(0, 7) == 0);
        default: out_ready = ($urandom_range(0, 29) == 0);
      endcase
    end
  end

  // Check results before noting requests taken at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(pitch_command, last_of_run, mode_after);
      if (in_valid && in_ready) sb.note_request(operation, detected, box_height);
    end
  end

  // Present one request from a falling edge and hold it until taken.
  task automatic send_request(input logic op, input logic det,
                              input logic [HEIGHT_BITS-1:0] h);
    in_valid   = 1'b1;
    operation  = op;
    detected   = det;
    box_height = h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int unsigned value);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value[CFG_DATA_BITS-1:0];
    sb.set_reg(idx, value[CFG_DATA_BITS-1:0]);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic configure(input int unsigned count, input int unsigned tol,
                           input int unsigned rate, input int unsigned ift);
    wait_idle();
    write_reg(REG_REQUIRED_COUNT, count);
    write_reg(REG_ANGLE_TOL, tol);
    write_reg(REG_MOVE_RATE, rate);
    write_reg(REG_INV_FRAME_TIME, ift);
  endtask

  // Mostly well-formed requests for the present mode, with some noise.
  task automatic pick_request(output logic op, output logic det,
                              output logic [HEIGHT_BITS-1:0] h);
    int unsigned r;
    int unsigned hv;
    r   = $urandom_range(0, 99);
    op  = 1'b0;
    det = ($urandom_range(0, 1) != 0);
    h   = HEIGHT_BITS'($urandom);
    if (r < 4) begin
      op = ($urandom_range(0, 1) != 0);
      return;
    end
    case (sb.mode)
      MODE_OFF: op = (r < 90);
      MODE_FIND, MODE_BACK: begin
        op  = (r >= 97);
        det = ($urandom_range(0, 9) != 0);
      end
      MODE_LEARN: op = (r >= 98);
      default: begin
        // Rectifying: heights near the peak so that alignment is reached.
        op  = (r >= 98);
        det = ($urandom_range(0, 9) != 0);
        case ($urandom_range(0, 3))
          0:       hv = sb.peak_height;
          1:       hv = (sb.peak_height > 8) ? sb.peak_height - $urandom_range(0, 8) : 0;
          2:       hv = $urandom_range(sb.peak_height, 4095);
          default: hv = $urandom_range(0, 4095);
        endcase
        h = hv[HEIGHT_BITS-1:0];
      end
    endcase
  endtask

  // Random requests in bursts, with gaps and the odd wait for all results.
  task automatic run_random(input int count);
    int                     burst_left;
    logic                   op;
    logic                   det;
    logic [HEIGHT_BITS-1:0] h;
    burst_left = 0;
    for (int k = 0; k < count; k++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 39) == 0) begin
          wait_idle();
        end else if ($urandom_range(0, 3) != 0) begin
          in_valid = 1'b0;
          repeat ($urandom_range(1, 15)) @(negedge clk);
        end
      end
      pick_request(op, det, h);
      send_request(op, det, h);
      burst_left--;
    end
    in_valid = 1'b0;
  endtask

  initial begin
    int n;
    sb = new;
    sb.reset_state();
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Directed: a full alignment with a zero-height box and a full-height peak.
    configure(2, 1144, 256, 7680);
    send_request(1'b0, 1'b1, 12'hFFF);
    send_request(1'b1, 1'b0, 12'h000);
    repeat (2) send_request(1'b0, 1'b1, 12'd300);
    send_request(1'b0, 1'b1, 12'd0);
    send_request(1'b0, 1'b1, 12'd4095);
    repeat (2) send_request(1'b0, 1'b0, 12'd0);
    send_request(1'b0, 1'b0, 12'd55);
    repeat (2) send_request(1'b0, 1'b1, 12'd1);
    send_request(1'b0, 1'b0, 12'd4095);
    send_request(1'b0, 1'b1, 12'd0);
    send_request(1'b0, 1'b1, 12'd2000);
    repeat (2) send_request(1'b0, 1'b1, 12'd4095);
    // Directed: learning sees no box, so the peak stays zero and any height exceeds it.
    send_request(1'b1, 1'b1, 12'd4095);
    repeat (2) send_request(1'b0, 1'b1, 12'd5);
    repeat (2) send_request(1'b0, 1'b0, 12'd9);
    repeat (2) send_request(1'b0, 1'b1, 12'd0);
    send_request(1'b0, 1'b1, 12'd7);
    send_request(1'b0, 1'b1, 12'd4095);

    // Random phases over several register settings, the extremes among them.
    for (int ph = 0; ph < PHASES; ph++) begin
      n = 166;
      case (ph)
        0: begin
          configure(3, 1144, 256, 7680);
          n = 150;
        end
        1: begin
          configure(1, 25736, 32767, 65535);
          n = 150;
        end
        2: begin
          configure(1, 1, 1, 1);
          n = 150;
        end
        3: begin
          configure(255, $urandom_range(1, 25736), $urandom_range(1, 32767),
                    $urandom_range(1, 65535));
          n = 100;
        end
        default: configure($urandom_range(1, 6), $urandom_range(200, 25736),
                           $urandom_range(1, 32767), $urandom_range(1, 65535));
      endcase
      run_random(n);
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> barcode_align_sequencer_unit.f
rtl/core/bas_pkg.sv
rtl/core/bas_tilt.sv
rtl/core/barcode_align_sequencer_unit.sv
verif/tb_barcode_align_sequencer_unit.sv
